FILE: rtl/core/mba_pkg.sv
// Shared constants and codes for the max-heap block allocator.
`timescale 1ns / 1ps
package mba_pkg;

  localparam int DEF_TABLE_ENTRIES = 64;
  localparam int DEF_ADDRESS_BITS  = 32;

  localparam int LEN_W      = 32;
  localparam int OUT_ADDR_W = 32;
  localparam int CFG_W      = 32;
  localparam int PADDR_W    = 3;

  localparam logic [LEN_W-1:0] RESET_REGION_LEN = 32'd65536;
  localparam logic [CFG_W-1:0] RESET_BASE       = 32'd0;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic REG_BASE = 1'b0;
  localparam logic REG_LEN  = 1'b1;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_BADHDL = 2'd2;

endpackage

FILE: rtl/core/mba_ram.sv
// Single write port, single registered read port memory.
`timescale 1ns / 1ps
module mba_ram #(
  parameter int W = 8,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mba_find.sv
// Lowest-index search for an unused block table entry.
`timescale 1ns / 1ps
module mba_find #(
  parameter int N = 64,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  used,
  output logic [IW-1:0] idx,
  output logic          found
);

  always_comb begin
    idx   = '0;
    found = 1'b0;
    // scan downwards so the lowest free entry wins
    for (int i = N - 1; i >= 0; i--) begin
      if (!used[i]) begin
        idx   = IW'(i);
        found = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/max_heap_block_allocator_core.sv
// Top level: block table, free-block max-heap and the request sequencer.
//
//  channel | direction | handshake            | payload
//  in_     | in        | in_valid / in_ready  | op, request_length, free_handle
//  out_    | out       | out_valid / out_ready| status, block_handle, address, length
//  cfg     | in        | APB psel/penable     | base_address, region_length
//
// Path to out_valid: an item refused at once is finished in IDLE; a splitting allocate
// passes S_A1 to S_A4 and then sifts the shrunk block down, and a free that merges both
// neighbours does a heap removal, then a sift up; each heap level takes a read state
// and a compare/write state. Reset and every register write rebuild the single free
// block in S_INIT; no item is taken during the rebuild. One item is in work at a time;
// the next is taken the cycle after the result enters the output register, and a
// stalled output holds the following result and the input.
`timescale 1ns / 1ps
module max_heap_block_allocator_core #(
  parameter int TABLE_ENTRIES = mba_pkg::DEF_TABLE_ENTRIES,
  parameter int ADDRESS_BITS  = mba_pkg::DEF_ADDRESS_BITS,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_op,
  input  logic [mba_pkg::LEN_W-1:0]       in_request_length,
  input  logic [IW-1:0]                   in_free_handle,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_status,
  output logic [IW-1:0]                   out_block_handle,
  output logic [mba_pkg::OUT_ADDR_W-1:0]  out_block_address,
  output logic [mba_pkg::LEN_W-1:0]       out_block_length,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mba_pkg::PADDR_W-1:0]     paddr,
  input  logic [mba_pkg::CFG_W-1:0]       pwdata,
  output logic [mba_pkg::CFG_W-1:0]       prdata,
  output logic                            pready
);

  localparam int LW = IW + 1;
  localparam int AB = ADDRESS_BITS;
  localparam int LN = mba_pkg::LEN_W;
  localparam int HW = LN + IW;
  localparam logic [LW-1:0] NONE = LW'(TABLE_ENTRIES);

  typedef enum logic [18:0] {
    S_INIT  = 19'b0000000000000000001,
    S_IDLE  = 19'b0000000000000000010,
    S_A1    = 19'b0000000000000000100,
    S_A2    = 19'b0000000000000001000,
    S_A3    = 19'b0000000000000010000,
    S_A4    = 19'b0000000000000100000,
    S_TKRD  = 19'b0000000000001000000,
    S_TK    = 19'b0000000000010000000,
    S_F1    = 19'b0000000000100000000,
    S_FPRD  = 19'b0000000001000000000,
    S_FPEX  = 19'b0000000010000000000,
    S_FN0   = 19'b0000000100000000000,
    S_FN1   = 19'b0000001000000000000,
    S_FQ0   = 19'b0000010000000000000,
    S_FQ1   = 19'b0000100000000000000,
    S_UPRD  = 19'b0001000000000000000,
    S_UPCMP = 19'b0010000000000000000,
    S_SDRD  = 19'b0100000000000000000,
    S_SDCMP = 19'b1000000000000000000
  } state_t;

  // S_FIN is folded into IDLE via fin_r and the pending result registers; results go out in IDLE
  state_t state_r, state_nxt, ret_r, ret_nxt;
  logic   fin_r, fin_nxt;

  logic [LW-1:0]            cnt_r, cnt_nxt;
  logic [TABLE_ENTRIES-1:0] in_use_r, in_use_nxt, free_r, free_nxt;
  logic [mba_pkg::CFG_W-1:0] base_r, base_nxt, rlen_r, rlen_nxt;

  logic [LN-1:0] req_r, req_nxt;
  logic [IW-1:0] h_r, h_nxt;
  logic [IW-1:0] c_slot_r, c_slot_nxt, c_ent_r, c_ent_nxt, newe_r, newe_nxt;
  logic [LN-1:0] c_len_r, c_len_nxt;
  logic          split_r, split_nxt;
  logic [LW-1:0] prv_r, prv_nxt, nxt_r, nxt_nxt;
  logic [AB-1:0] acc_start_r, acc_start_nxt;
  logic [LN-1:0] acc_len_r, acc_len_nxt;
  logic [IW-1:0] hole_r, hole_nxt, x_ent_r, x_ent_nxt;
  logic [LN-1:0] x_len_r, x_len_nxt;
  logic          down_r, down_nxt, moved_r, moved_nxt;

  logic [1:0]    pend_status_r, pend_status_nxt;
  logic [IW-1:0] pend_handle_r, pend_handle_nxt;
  logic [31:0]   pend_addr_r, pend_addr_nxt;
  logic [LN-1:0] pend_len_r, pend_len_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    out_status_r, out_status_nxt;
  logic [IW-1:0] out_handle_r, out_handle_nxt;
  logic [31:0]   out_addr_r, out_addr_nxt;
  logic [LN-1:0] out_len_r, out_len_nxt;

  // memory ports
  logic          hp_we;
  logic [IW-1:0] hp_wa, hp_ra_a, hp_ra_b;
  logic [HW-1:0] hp_wd, hp_rd_a, hp_rd_b;
  logic          pos_we;
  logic [IW-1:0] pos_wa, pos_wd, pos_ra, pos_rd;
  logic [IW-1:0] ent_ra;
  logic          st_we, ln_we, pv_we, nx_we;
  logic [IW-1:0] st_wa, ln_wa, pv_wa, nx_wa;
  logic [AB-1:0] st_wd, st_rd;
  logic [LN-1:0] ln_wd, ln_rd;
  logic [LW-1:0] pv_wd, pv_rd, nx_wd, nx_rd;

  logic [IW-1:0] find_idx;
  logic          find_ok;

  mba_ram #(.W(HW), .D(TABLE_ENTRIES)) u_heap_a (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra_a), .rdata(hp_rd_a));
  mba_ram #(.W(HW), .D(TABLE_ENTRIES)) u_heap_b (
    .clk(clk), .we(hp_we), .waddr(hp_wa), .wdata(hp_wd), .raddr(hp_ra_b), .rdata(hp_rd_b));
  mba_ram #(.W(IW), .D(TABLE_ENTRIES)) u_pos (
    .clk(clk), .we(pos_we), .waddr(pos_wa), .wdata(pos_wd), .raddr(pos_ra), .rdata(pos_rd));
  mba_ram #(.W(AB), .D(TABLE_ENTRIES)) u_start (
    .clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd), .raddr(ent_ra), .rdata(st_rd));
  mba_ram #(.W(LN), .D(TABLE_ENTRIES)) u_len (
    .clk(clk), .we(ln_we), .waddr(ln_wa), .wdata(ln_wd), .raddr(ent_ra), .rdata(ln_rd));
  mba_ram #(.W(LW), .D(TABLE_ENTRIES)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(ent_ra), .rdata(pv_rd));
  mba_ram #(.W(LW), .D(TABLE_ENTRIES)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(ent_ra), .rdata(nx_rd));

  mba_find #(.N(TABLE_ENTRIES)) u_find (.used(in_use_r), .idx(find_idx), .found(find_ok));

  // heap slot fields
  logic [LN-1:0] a_len, b_len;
  logic [IW-1:0] a_ent, b_ent;
  assign a_len = hp_rd_a[HW-1:IW];
  assign a_ent = hp_rd_a[IW-1:0];
  assign b_len = hp_rd_b[HW-1:IW];
  assign b_ent = hp_rd_b[IW-1:0];

  logic          cfg_we;
  logic          in_acc;
  logic [LW-1:0] last_slot;
  logic [IW-1:0] parent;
  logic [IW+1:0] lc, rc;
  logic          lv, rv, take_l, take_r;
  logic [LN-1:0] big_len;
  logic          v2;
  logic [IW-1:0] v_slot, v_ent;
  logic [LN-1:0] v_len;
  logic          nfree, pfree;
  logic [LN-1:0] merged_len;

  assign cfg_we    = psel & penable & pwrite;
  assign in_ready  = (state_r == S_IDLE) && !fin_r;
  assign in_acc    = in_valid & in_ready;
  assign last_slot = cnt_r - LW'(1);
  assign parent    = IW'((hole_r - IW'(1)) >> 1);
  assign lc        = {1'b0, hole_r, 1'b1};
  assign rc        = lc + (IW+2)'(1);
  assign lv        = lc < (IW+2)'(cnt_r);
  assign rv        = rc < (IW+2)'(cnt_r);
  assign take_l    = lv && (a_len > x_len_r);
  assign big_len   = take_l ? a_len : x_len_r;
  assign take_r    = rv && (b_len > big_len);
  assign v2        = (cnt_r > LW'(2)) && (a_len >= req_r) && (a_len < c_len_r);
  assign v_slot    = v2 ? IW'(2) : c_slot_r;
  assign v_ent     = v2 ? a_ent : c_ent_r;
  assign v_len     = v2 ? a_len : c_len_r;
  assign nfree     = (nx_rd < NONE) && free_r[nx_rd[IW-1:0]];
  assign pfree     = (pv_rd < NONE) && free_r[pv_rd[IW-1:0]];
  assign merged_len = ln_rd + acc_len_r;

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;  fin_nxt = fin_r;
    cnt_nxt = cnt_r;  in_use_nxt = in_use_r;  free_nxt = free_r;
    base_nxt = base_r;  rlen_nxt = rlen_r;
    req_nxt = req_r;  h_nxt = h_r;
    c_slot_nxt = c_slot_r;  c_ent_nxt = c_ent_r;  c_len_nxt = c_len_r;
    newe_nxt = newe_r;  split_nxt = split_r;
    prv_nxt = prv_r;  nxt_nxt = nxt_r;
    acc_start_nxt = acc_start_r;  acc_len_nxt = acc_len_r;
    hole_nxt = hole_r;  x_ent_nxt = x_ent_r;  x_len_nxt = x_len_r;
    down_nxt = down_r;  moved_nxt = moved_r;
    pend_status_nxt = pend_status_r;  pend_handle_nxt = pend_handle_r;
    pend_addr_nxt = pend_addr_r;  pend_len_nxt = pend_len_r;
    out_valid_nxt = out_valid_r;  out_status_nxt = out_status_r;
    out_handle_nxt = out_handle_r;  out_addr_nxt = out_addr_r;  out_len_nxt = out_len_r;

    hp_we = 1'b0;  hp_wa = '0;  hp_wd = '0;  hp_ra_a = '0;  hp_ra_b = IW'(1);
    pos_we = 1'b0;  pos_wa = '0;  pos_wd = '0;  pos_ra = '0;
    ent_ra = '0;
    st_we = 1'b0;  st_wa = '0;  st_wd = '0;
    ln_we = 1'b0;  ln_wa = '0;  ln_wd = '0;
    pv_we = 1'b0;  pv_wa = '0;  pv_wd = '0;
    nx_we = 1'b0;  nx_wa = '0;  nx_wd = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        st_we = 1'b1;  st_wa = '0;  st_wd = AB'(base_r);
        ln_we = 1'b1;  ln_wa = '0;  ln_wd = LN'(rlen_r);
        pv_we = 1'b1;  pv_wa = '0;  pv_wd = NONE;
        nx_we = 1'b1;  nx_wa = '0;  nx_wd = NONE;
        hp_we = 1'b1;  hp_wa = '0;  hp_wd = {LN'(rlen_r), IW'(0)};
        pos_we = 1'b1; pos_wa = '0; pos_wd = '0;
        in_use_nxt = TABLE_ENTRIES'(1);
        free_nxt   = TABLE_ENTRIES'(1);
        cnt_nxt    = LW'(1);
        fin_nxt    = 1'b0;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        hp_ra_a = '0;
        hp_ra_b = IW'(1);
        ent_ra  = in_free_handle;
        if (fin_r) begin
          // hold the result until the output register frees up
          if (!out_valid_r || out_ready) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = pend_status_r;
            out_handle_nxt = pend_handle_r;
            out_addr_nxt   = pend_addr_r;
            out_len_nxt    = pend_len_r;
            fin_nxt        = 1'b0;
          end
        end else if (in_acc) begin
          req_nxt = in_request_length;
          h_nxt   = in_free_handle;
          pend_status_nxt = mba_pkg::ST_OK;
          pend_handle_nxt = '0;
          pend_addr_nxt   = '0;
          pend_len_nxt    = '0;
          if (in_op == mba_pkg::OP_ALLOC) begin
            if (cnt_r == '0) begin
              pend_status_nxt = mba_pkg::ST_NOFIT;
              fin_nxt = 1'b1;
            end else begin
              state_nxt = S_A1;
            end
          end else begin
            if ((LW'(in_free_handle) >= NONE) || !in_use_r[in_free_handle]
                || free_r[in_free_handle]) begin
              pend_status_nxt = mba_pkg::ST_BADHDL;
              fin_nxt = 1'b1;
            end else begin
              state_nxt = S_F1;
            end
          end
        end
      end
      S_A1: begin
        hp_ra_a = IW'(2);
        if (req_r > a_len) begin
          pend_status_nxt = mba_pkg::ST_NOFIT;
          fin_nxt   = 1'b1;
          state_nxt = S_IDLE;
        end else if ((cnt_r > LW'(1)) && (b_len >= req_r)) begin
          c_slot_nxt = IW'(1);  c_ent_nxt = b_ent;  c_len_nxt = b_len;
          state_nxt  = S_A2;
        end else begin
          c_slot_nxt = '0;  c_ent_nxt = a_ent;  c_len_nxt = a_len;
          state_nxt  = S_A2;
        end
      end
      S_A2: begin
        ent_ra     = v_ent;
        c_slot_nxt = v_slot;
        c_ent_nxt  = v_ent;
        c_len_nxt  = v_len;
        newe_nxt   = find_idx;
        split_nxt  = (v_len != req_r) && find_ok;
        state_nxt  = S_A3;
      end
      S_A3: begin
        if (split_r) begin
          st_we = 1'b1;  st_wa = newe_r;  st_wd = st_rd;
          ln_we = 1'b1;  ln_wa = newe_r;  ln_wd = req_r;
          pv_we = 1'b1;  pv_wa = newe_r;  pv_wd = pv_rd;
          nx_we = 1'b1;  nx_wa = newe_r;  nx_wd = LW'(c_ent_r);
          in_use_nxt[newe_r] = 1'b1;
          prv_nxt       = pv_rd;
          acc_start_nxt = st_rd;
          pend_handle_nxt = newe_r;
          pend_addr_nxt   = 32'(st_rd);
          pend_len_nxt    = req_r;
          state_nxt = S_A4;
        end else begin
          // no split: grant the whole block and take it out of the heap
          free_nxt[c_ent_r] = 1'b0;
          pend_handle_nxt = c_ent_r;
          pend_addr_nxt   = 32'(st_rd);
          pend_len_nxt    = c_len_r;
          hole_nxt  = c_slot_r;
          ret_nxt   = S_IDLE;
          state_nxt = S_TKRD;
        end
      end
      S_A4: begin
        if (prv_r < NONE) begin
          nx_we = 1'b1;  nx_wa = prv_r[IW-1:0];  nx_wd = LW'(newe_r);
        end
        pv_we = 1'b1;  pv_wa = c_ent_r;  pv_wd = LW'(newe_r);
        st_we = 1'b1;  st_wa = c_ent_r;  st_wd = acc_start_r + AB'(req_r);
        ln_we = 1'b1;  ln_wa = c_ent_r;  ln_wd = c_len_r - req_r;
        x_len_nxt = c_len_r - req_r;
        x_ent_nxt = c_ent_r;
        hole_nxt  = c_slot_r;
        ret_nxt   = S_IDLE;
        state_nxt = S_SDRD;
      end
      S_TKRD: begin
        hp_ra_a   = last_slot[IW-1:0];
        state_nxt = S_TK;
      end
      S_TK: begin
        cnt_nxt = last_slot;
        if (LW'(hole_r) == last_slot) begin
          fin_nxt   = (ret_r == S_IDLE);
          state_nxt = ret_r;
        end else begin
          x_len_nxt = a_len;
          x_ent_nxt = a_ent;
          down_nxt  = 1'b1;
          moved_nxt = 1'b0;
          state_nxt = S_UPRD;
        end
      end
      S_F1: begin
        acc_start_nxt = st_rd;
        acc_len_nxt   = ln_rd;
        prv_nxt       = pv_rd;
        nxt_nxt       = nx_rd;
        if (nfree) begin
          state_nxt = pfree ? S_FPRD : S_FN0;
        end else if (pfree) begin
          state_nxt = S_FQ0;
        end else begin
          // no free neighbour: insert as a new heap leaf
          x_len_nxt = ln_rd;
          x_ent_nxt = h_r;
          hole_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + LW'(1);
          free_nxt[h_r] = 1'b1;
          down_nxt  = 1'b0;
          moved_nxt = 1'b0;
          ret_nxt   = S_IDLE;
          state_nxt = S_UPRD;
        end
      end
      S_FPRD: begin
        ent_ra    = prv_r[IW-1:0];
        pos_ra    = prv_r[IW-1:0];
        state_nxt = S_FPEX;
      end
      S_FPEX: begin
        acc_start_nxt = st_rd;
        acc_len_nxt   = acc_len_r + ln_rd;
        prv_nxt       = pv_rd;
        in_use_nxt[prv_r[IW-1:0]] = 1'b0;
        free_nxt[prv_r[IW-1:0]]   = 1'b0;
        hole_nxt  = pos_rd;
        ret_nxt   = S_FN0;
        state_nxt = S_TKRD;
      end
      S_FN0: begin
        ent_ra    = nxt_r[IW-1:0];
        pos_ra    = nxt_r[IW-1:0];
        state_nxt = S_FN1;
      end
      S_FN1: begin
        ln_we = 1'b1;  ln_wa = nxt_r[IW-1:0];  ln_wd = merged_len;
        st_we = 1'b1;  st_wa = nxt_r[IW-1:0];  st_wd = acc_start_r;
        pv_we = 1'b1;  pv_wa = nxt_r[IW-1:0];  pv_wd = prv_r;
        if (prv_r < NONE) begin
          nx_we = 1'b1;  nx_wa = prv_r[IW-1:0];  nx_wd = nxt_r;
        end
        in_use_nxt[h_r] = 1'b0;
        x_len_nxt = merged_len;
        x_ent_nxt = nxt_r[IW-1:0];
        hole_nxt  = pos_rd;
        down_nxt  = 1'b0;
        moved_nxt = 1'b0;
        ret_nxt   = S_IDLE;
        state_nxt = S_UPRD;
      end
      S_FQ0: begin
        ent_ra    = prv_r[IW-1:0];
        pos_ra    = prv_r[IW-1:0];
        state_nxt = S_FQ1;
      end
      S_FQ1: begin
        ln_we = 1'b1;  ln_wa = prv_r[IW-1:0];  ln_wd = merged_len;
        nx_we = 1'b1;  nx_wa = prv_r[IW-1:0];  nx_wd = nxt_r;
        if (nxt_r < NONE) begin
          pv_we = 1'b1;  pv_wa = nxt_r[IW-1:0];  pv_wd = prv_r;
        end
        in_use_nxt[h_r] = 1'b0;
        x_len_nxt = merged_len;
        x_ent_nxt = prv_r[IW-1:0];
        hole_nxt  = pos_rd;
        down_nxt  = 1'b0;
        moved_nxt = 1'b0;
        ret_nxt   = S_IDLE;
        state_nxt = S_UPRD;
      end
      S_UPRD: begin
        hp_ra_a   = parent;
        state_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if ((hole_r != '0) && (x_len_r > a_len)) begin
          // pull the parent down into the hole and climb
          hp_we = 1'b1;  hp_wa = hole_r;  hp_wd = hp_rd_a;
          pos_we = 1'b1; pos_wa = a_ent;  pos_wd = hole_r;
          hole_nxt  = parent;
          moved_nxt = 1'b1;
          state_nxt = S_UPRD;
        end else if (down_r && !moved_r) begin
          state_nxt = S_SDRD;
        end else begin
          hp_we = 1'b1;  hp_wa = hole_r;  hp_wd = {x_len_r, x_ent_r};
          pos_we = 1'b1; pos_wa = x_ent_r; pos_wd = hole_r;
          fin_nxt   = (ret_r == S_IDLE);
          state_nxt = ret_r;
        end
      end
      S_SDRD: begin
        hp_ra_a   = lc[IW-1:0];
        hp_ra_b   = rc[IW-1:0];
        state_nxt = S_SDCMP;
      end
      S_SDCMP: begin
        if (take_r) begin
          hp_we = 1'b1;  hp_wa = hole_r;  hp_wd = hp_rd_b;
          pos_we = 1'b1; pos_wa = b_ent;  pos_wd = hole_r;
          hole_nxt  = rc[IW-1:0];
          state_nxt = S_SDRD;
        end else if (take_l) begin
          hp_we = 1'b1;  hp_wa = hole_r;  hp_wd = hp_rd_a;
          pos_we = 1'b1; pos_wa = a_ent;  pos_wd = hole_r;
          hole_nxt  = lc[IW-1:0];
          state_nxt = S_SDRD;
        end else begin
          hp_we = 1'b1;  hp_wa = hole_r;  hp_wd = {x_len_r, x_ent_r};
          pos_we = 1'b1; pos_wa = x_ent_r; pos_wd = hole_r;
          fin_nxt   = (ret_r == S_IDLE);
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase

    if (cfg_we) begin
      if (paddr[2] == mba_pkg::REG_BASE) begin
        base_nxt = pwdata;
      end else begin
        rlen_nxt = pwdata;
      end
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ret_r       <= S_IDLE;
      fin_r       <= 1'b0;
      cnt_r       <= LW'(1);
      in_use_r    <= TABLE_ENTRIES'(1);
      free_r      <= TABLE_ENTRIES'(1);
      base_r      <= mba_pkg::RESET_BASE;
      rlen_r      <= mba_pkg::RESET_REGION_LEN;
      out_valid_r <= 1'b0;
      down_r      <= 1'b0;
      moved_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      fin_r       <= fin_nxt;
      cnt_r       <= cnt_nxt;
      in_use_r    <= in_use_nxt;
      free_r      <= free_nxt;
      base_r      <= base_nxt;
      rlen_r      <= rlen_nxt;
      out_valid_r <= out_valid_nxt;
      down_r      <= down_nxt;
      moved_r     <= moved_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    h_r           <= h_nxt;
    c_slot_r      <= c_slot_nxt;
    c_ent_r       <= c_ent_nxt;
    c_len_r       <= c_len_nxt;
    newe_r        <= newe_nxt;
    split_r       <= split_nxt;
    prv_r         <= prv_nxt;
    nxt_r         <= nxt_nxt;
    acc_start_r   <= acc_start_nxt;
    acc_len_r     <= acc_len_nxt;
    hole_r        <= hole_nxt;
    x_ent_r       <= x_ent_nxt;
    x_len_r       <= x_len_nxt;
    pend_status_r <= pend_status_nxt;
    pend_handle_r <= pend_handle_nxt;
    pend_addr_r   <= pend_addr_nxt;
    pend_len_r    <= pend_len_nxt;
    out_status_r  <= out_status_nxt;
    out_handle_r  <= out_handle_nxt;
    out_addr_r    <= out_addr_nxt;
    out_len_r     <= out_len_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_handle  = out_handle_r;
  assign out_block_address = out_addr_r;
  assign out_block_length  = out_len_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == mba_pkg::REG_LEN) ? rlen_r : base_r;

endmodule

FILE: rtl/core/mba_checker.sv
// Port-level checks for the block allocator, bound to the top level.
`timescale 1ns / 1ps
module mba_checker #(
  parameter int TABLE_ENTRIES = mba_pkg::DEF_TABLE_ENTRIES,
  localparam int IW = $clog2(TABLE_ENTRIES)
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_status,
  input logic [IW-1:0]                  out_block_handle,
  input logic [mba_pkg::OUT_ADDR_W-1:0] out_block_address,
  input logic [mba_pkg::LEN_W-1:0]      out_block_length
);

  // a result stays valid with status and length unchanged until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_block_length))
    else $error("result dropped or changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == mba_pkg::ST_OK) || (out_status == mba_pkg::ST_NOFIT)
      || (out_status == mba_pkg::ST_BADHDL))
    else $error("undefined status code");

  // failed requests carry no block
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mba_pkg::ST_OK) |-> (out_block_handle == '0)
      && (out_block_address == '0) && (out_block_length == '0))
    else $error("failed request carries block fields");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

endmodule

bind max_heap_block_allocator_core mba_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mba_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_block_handle(out_block_handle), .out_block_address(out_block_address),
  .out_block_length(out_block_length));

FILE: bench/max_heap_block_allocator_core_tb.sv
// Self-checking bench for the max-heap block allocator core.
`timescale 1ns / 1ps
module max_heap_block_allocator_core_tb;

  localparam int N = 64;
  localparam int NONE = 64;
  localparam int LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = mba_pkg::OP_ALLOC;
  logic [31:0] in_request_length = '0;
  logic [5:0] in_free_handle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [5:0] out_block_handle;
  logic [31:0] out_block_address;
  logic [31:0] out_block_length;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [mba_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  max_heap_block_allocator_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] handle;
    logic [31:0] addr;
    logic [31:0] len;
  } grant_t;

  grant_t grants_due[$];
  int errors = 0;
  int cycles = 0;
  int n_items = 0;
  int n_results = 0;
  int n_cfg = 0;
  int send_idle = 0;
  int recv_idle = 0;

  // predictor state
  logic [31:0] cur_base, cur_len;
  logic [31:0] blk_start[N];
  logic [31:0] blk_len[N];
  int blk_prev[N], blk_next[N], hpos[N], hslot[N];
  bit blk_free[N], blk_used[N];
  int hcount;

  function automatic void rebuild();
    for (int i = 0; i < N; i++) begin
      blk_start[i] = '0; blk_len[i] = '0;
      blk_prev[i] = NONE; blk_next[i] = NONE;
      blk_free[i] = 0; blk_used[i] = 0;
      hpos[i] = NONE; hslot[i] = 0;
    end
    blk_start[0] = cur_base; blk_len[0] = cur_len;
    blk_free[0] = 1; blk_used[0] = 1; hpos[0] = 0; hcount = 1;
  endfunction

  function automatic logic [31:0] slen(int s);
    return blk_len[hslot[s] % NONE];
  endfunction

  function automatic void swap_slots(int a, int b);
    int ea, eb;
    ea = hslot[a]; eb = hslot[b];
    hslot[a] = eb; hslot[b] = ea;
    hpos[eb % NONE] = a; hpos[ea % NONE] = b;
  endfunction

  function automatic void rise(int p);
    int par;
    while (p > 0 && p < hcount) begin
      par = (p - 1) / 2;
      if (!(slen(p) > slen(par))) break;
      swap_slots(p, par);
      p = par;
    end
  endfunction

  function automatic void sink(int p);
    int l, r, big;
    while (p < hcount) begin
      l = 2 * p + 1; r = 2 * p + 2; big = p;
      if (l < hcount && slen(l) > slen(big)) big = l;
      if (r < hcount && slen(r) > slen(big)) big = r;
      if (big == p) break;
      swap_slots(p, big);
      p = big;
    end
  endfunction

  function automatic void heap_remove(int e);
    int p, last;
    p = hpos[e];
    if (p >= hcount || hcount == 0) return;
    last = hcount - 1;
    hpos[e] = NONE;
    if (p == last) begin
      hcount = last;
      return;
    end
    hslot[p] = hslot[last];
    hpos[hslot[p] % NONE] = p;
    hcount = last;
    rise(p);
    sink(hpos[hslot[p] % NONE] == p ? p : NONE);
  endfunction

  function automatic void unlink(int e);
    int p, n;
    p = blk_prev[e]; n = blk_next[e];
    if (p < NONE) blk_next[p] = n;
    if (n < NONE) blk_prev[n] = p;
    blk_prev[e] = NONE; blk_next[e] = NONE;
    blk_used[e] = 0; blk_free[e] = 0; hpos[e] = NONE;
    blk_start[e] = '0; blk_len[e] = '0;
  endfunction

  function automatic bit nb_free(int l);
    return l < NONE && blk_free[l];
  endfunction

  function automatic grant_t serve(logic op, logic [31:0] req, logic [5:0] h);
    grant_t g;
    int v, e, ne, p, n;
    g = '0;
    if (op == mba_pkg::OP_ALLOC) begin
      if (hcount == 0 || req > slen(0)) begin
        g.status = mba_pkg::ST_NOFIT;
        return g;
      end
      v = 0;
      if (hcount > 1 && slen(1) >= req) v = 1;
      if (hcount > 2 && slen(2) >= req && slen(2) < slen(v)) v = 2;
      e = hslot[v] % NONE;
      ne = NONE;
      if (blk_len[e] != req)
        for (int i = 0; i < N; i++)
          if (!blk_used[i]) begin
            ne = i;
            break;
          end
      if (ne == NONE) begin
        heap_remove(e);
        blk_free[e] = 0;
        g.handle = 6'(e); g.addr = blk_start[e]; g.len = blk_len[e];
        return g;
      end
      blk_used[ne] = 1; blk_free[ne] = 0; hpos[ne] = NONE;
      blk_start[ne] = blk_start[e]; blk_len[ne] = req;
      blk_prev[ne] = blk_prev[e]; blk_next[ne] = e;
      if (blk_prev[e] < NONE) blk_next[blk_prev[e]] = ne;
      blk_prev[e] = ne;
      blk_start[e] = blk_start[e] + req;
      blk_len[e] = blk_len[e] - req;
      sink(hpos[e]);
      g.handle = 6'(ne); g.addr = blk_start[ne]; g.len = req;
      return g;
    end
    if (!blk_used[h] || blk_free[h]) begin
      g.status = mba_pkg::ST_BADHDL;
      return g;
    end
    p = blk_prev[h]; n = blk_next[h];
    if (nb_free(n)) begin
      if (nb_free(p)) begin
        blk_len[h] = blk_len[h] + blk_len[p];
        blk_start[h] = blk_start[p];
        heap_remove(p);
        unlink(p);
      end
      blk_len[n] = blk_len[n] + blk_len[h];
      blk_start[n] = blk_start[h];
      unlink(h);
      rise(hpos[n]);
    end else if (nb_free(p)) begin
      blk_len[p] = blk_len[p] + blk_len[h];
      unlink(h);
      rise(hpos[p]);
    end else if (hcount < NONE) begin
      hslot[hcount] = h; hpos[h] = hcount; blk_free[h] = 1;
      hcount++;
      rise(hcount - 1);
    end
    return g;
  endfunction

  // directed rows: known marks the rows whose result is typed in
  typedef struct {
    logic op;
    logic [31:0] req;
    logic [5:0] h;
    bit known;
    grant_t want;
  } row_t;

  row_t rows[] = '{
    '{mba_pkg::OP_ALLOC, 32'd65537, 6'd0, 1, '{mba_pkg::ST_NOFIT, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_FREE, 32'd0, 6'd5, 1, '{mba_pkg::ST_BADHDL, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_FREE, 32'd0, 6'd0, 1, '{mba_pkg::ST_BADHDL, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_ALLOC, 32'd16, 6'd0, 1, '{mba_pkg::ST_OK, 6'd1, 32'd0, 32'd16}},
    '{mba_pkg::OP_ALLOC, 32'd0, 6'd0, 0, '0},
    '{mba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 6'd0, 1,
      '{mba_pkg::ST_NOFIT, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_ALLOC, 32'd100, 6'd63, 0, '0},
    '{mba_pkg::OP_ALLOC, 32'd300, 6'd0, 0, '0},
    '{mba_pkg::OP_FREE, 32'd0, 6'd3, 0, '0},
    '{mba_pkg::OP_FREE, 32'd0, 6'd3, 1, '{mba_pkg::ST_BADHDL, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_FREE, 32'd0, 6'd1, 0, '0},
    '{mba_pkg::OP_FREE, 32'd0, 6'd4, 0, '0},
    '{mba_pkg::OP_FREE, 32'd0, 6'd2, 0, '0},
    '{mba_pkg::OP_ALLOC, 32'd65536, 6'd0, 0, '0},
    '{mba_pkg::OP_ALLOC, 32'd1, 6'd0, 1, '{mba_pkg::ST_NOFIT, 6'd0, 32'd0, 32'd0}},
    '{mba_pkg::OP_FREE, 32'd0, 6'd0, 0, '0},
    '{mba_pkg::OP_FREE, 32'd0, 6'd63, 1, '{mba_pkg::ST_BADHDL, 6'd0, 32'd0, 32'd0}}
  };

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // result side: random stall and checking
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      n_results <= n_results + 1;
      if (grants_due.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (out_status !== g.status) begin
          $error("status: expected %0d got %0d", g.status, out_status); errors++;
        end
        if (out_block_handle !== g.handle) begin
          $error("block_handle: expected %0d got %0d", g.handle, out_block_handle);
          errors++;
        end
        if (out_block_address !== g.addr) begin
          $error("block_address: expected %h got %h", g.addr, out_block_address);
          errors++;
        end
        if (out_block_length !== g.len) begin
          $error("block_length: expected %h got %h", g.len, out_block_length);
          errors++;
        end
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
  end

  // valid stays high from one item to the next unless the sender idles
  task automatic send(logic op, logic [31:0] req, logic [5:0] h, bit known, grant_t want);
    grant_t g;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op; in_request_length <= req; in_free_handle <= h;
    do @(posedge clk); while (!in_ready);
    g = serve(op, req, h);
    if (known && g !== want) begin
      $error("directed row: predictor %h table %h", g, want);
      errors++;
    end
    grants_due.push_back(g);
    n_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= mba_pkg::PADDR_W'(4 * idx); pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == mba_pkg::REG_BASE) cur_base = val; else cur_len = val;
    rebuild();
    n_cfg++;
    @(posedge clk);
  endtask

  // allocate-heavy traffic with frees of plausible handles
  task automatic random_items(int count, logic [31:0] len_cap);
    logic [31:0] r;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: r = $urandom;
        1: r = $urandom_range(3);
        default: r = $urandom_range(len_cap);
      endcase
      if ($urandom_range(99) < 52)
        send(mba_pkg::OP_ALLOC, r, 6'($urandom_range(63)), 0, '0);
      else
        send(mba_pkg::OP_FREE, $urandom, 6'($urandom_range(63)), 0, '0);
    end
  endtask

  initial begin
    logic [31:0] bases[4];
    logic [31:0] lens[4];
    cur_base = mba_pkg::RESET_BASE; cur_len = mba_pkg::RESET_REGION_LEN;
    rebuild();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    foreach (rows[i]) send(rows[i].op, rows[i].req, rows[i].h, rows[i].known, rows[i].want);
    drain();

    bases = '{32'hFFFF_FF00, 32'h0, 32'h8000_0000, 32'h1234_5678};
    lens = '{32'hFFFF_FFFF, 32'd1, 32'd4096, 32'd65536};
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle = 0; recv_idle = 0; end
        1: begin send_idle = 49; recv_idle = 0; end
        2: begin send_idle = 0; recv_idle = 49; end
        default: begin send_idle = 26; recv_idle = 26; end
      endcase
      write_reg(mba_pkg::REG_BASE, bases[ph]);
      write_reg(mba_pkg::REG_LEN, lens[ph]);
      random_items(200, (lens[ph] > 32'd100000) ? lens[ph] >> 3 : lens[ph] >> 2);
      // hold off until everything is back, then continue
      drain();
      random_items(200, (lens[ph] > 32'd100000) ? 32'hFFFF_FF : lens[ph] >> 4);
      drain();
    end
    send_idle = 0; recv_idle = 0;
    drain();

    $display("%0d items, %0d results, %0d register writes, four idle patterns",
             n_items, n_results, n_cfg);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
